// ----- hw/rtl/text_encoding_classifier_unit_assert.svh -----
// Assertion macros for the text encoding classifier.
// Included by the top level; depends on nothing else.
`ifndef TEXT_ENCODING_CLASSIFIER_UNIT_ASSERT_SVH
`define TEXT_ENCODING_CLASSIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tec_pkg.sv -----
// Shared types, constants and helper functions of the text encoding classifier.
// Used by all RTL modules of the block; depends on nothing.
package tec_pkg;

    localparam int MAX_SEQ_BYTES_DEF = 6;

    localparam logic [2:0] CLS_BINARY   = 3'd0;
    localparam logic [2:0] CLS_ASCII    = 3'd1;
    localparam logic [2:0] CLS_HIGH     = 3'd2;
    localparam logic [2:0] CLS_UTF8     = 3'd3;
    localparam logic [2:0] CLS_UTF8_BOM = 3'd4;
    localparam logic [2:0] CLS_EMPTY    = 3'd5;
    localparam logic [2:0] CLS_UTF16LE  = 3'd6;
    localparam logic [2:0] CLS_UTF16BE  = 3'd7;

    localparam logic [7:0] BYTE_SUB = 8'h1A;
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_FE  = 8'hFE;
    localparam logic [7:0] BYTE_EF  = 8'hEF;
    localparam logic [7:0] BYTE_BB  = 8'hBB;
    localparam logic [7:0] BYTE_BF  = 8'hBF;

    localparam logic [31:0] SURR_LO  = 32'h0000_D800;
    localparam logic [31:0] SURR_HI  = 32'h0000_DFFF;
    localparam logic [31:0] NONCHAR0 = 32'h0000_FFFE;
    localparam logic [31:0] NONCHAR1 = 32'h0000_FFFF;

    typedef enum logic [1:0] {
        TXT_ASCII,
        TXT_UTF8,
        TXT_HIGH
    } t_text;

    typedef struct packed {
        logic       valid;
        logic [2:0] cls;
    } t_result;

    function automatic logic [3:0] count_lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] min_code(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd2:    m = 32'h0000_0080;
            3'd3:    m = 32'h0000_0800;
            3'd4:    m = 32'h0001_0000;
            3'd5:    m = 32'h0020_0000;
            3'd6:    m = 32'h0400_0000;
            3'd7:    m = 32'h8000_0000;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic is_forbidden(input logic [7:0] c);
        return (c < 8'h20) && !(c inside {8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
    endfunction

endpackage

// ----- hw/rtl/text_encoding_classifier_unit.sv -----
// Text encoding classifier: one stream byte or end word per cycle, one class per stream.
// The class is registered in the result register as the end word leaves the input register.
// Throughput: one word per cycle while o_stall is low; byte words never wait on the output side.
// An end word waits in the input register only while the result register is full and stalled.
// Reset (i_rst_n low, synchronous) empties both registers and restores the idle stream state.
// Depends on tec_pkg, tec_core, tec_out_stage and the assertion macro header.
`include "text_encoding_classifier_unit_assert.svh"

module text_encoding_classifier_unit #(
    parameter int MAX_SEQ_BYTES = tec_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_end_marker,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_encoding_class
);

    tec_pkg::t_result w_res;
    logic             w_out_free;

    tec_core #(
        .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_value (i_byte_value),
        .i_end_marker (i_end_marker),
        .i_out_free   (w_out_free),
        .o_res        (w_res)
    );

    tec_out_stage u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res            (w_res),
        .o_out_free       (w_out_free),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_encoding_class (o_encoding_class)
    );

    `TEC_ASSERT_NOW(a_rise_from_end, i_clk, i_rst_n, $rose(o_valid), $past(w_res.valid), "result word appeared without an end word")
    `TEC_ASSERT_NOW(a_end_waits, i_clk, i_rst_n, o_valid && i_stall && w_res.valid, o_stall, "end word advanced into a full result register")
    `TEC_ASSERT_NEXT(a_end_delivered, i_clk, i_rst_n, w_res.valid && !o_stall, o_valid, "end word advanced but no result word followed")

endmodule

// ----- hw/rtl/tec_core.sv -----
// Input register and per-word classification state of the text encoding classifier.
// Depends on tec_pkg.
module tec_core #(
    parameter int MAX_SEQ_BYTES = tec_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_byte_value,
    input  logic              i_end_marker,
    input  logic              i_out_free,
    output tec_pkg::t_result  o_res
);

    localparam int CODE_W = 5 * MAX_SEQ_BYTES + 1;

    logic              r_v;
    logic [7:0]        r_byte;
    logic              r_end;

    logic [1:0]        r_bom_pos, n_bom_pos;
    logic [2:0]        r_bom_poss, n_bom_poss;
    logic              r_decided, n_decided;
    logic [2:0]        r_dec_class, n_dec_class;
    tec_pkg::t_text    r_text, n_text;
    logic              r_sub, n_sub;
    logic [2:0]        r_seq_len, n_seq_len;
    logic [3:0]        r_lead, n_lead;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_any, n_any;

    logic              w_advance;
    logic [2:0]        w_bits;
    logic [3:0]        w_lead;
    logic [31:0]       w_code32;
    logic              w_seq_ok;
    logic              w_close_bad;
    tec_pkg::t_text    w_text;
    tec_pkg::t_text    w_text_fin;
    logic [2:0]        w_cls;

    assign w_advance = r_v && (!r_end || i_out_free);
    assign o_stall   = r_v && !w_advance;

    assign w_lead   = tec_pkg::count_lead_ones(r_byte);
    assign w_code32 = 32'(r_code);

    assign w_seq_ok = (r_seq_len >= 3'd2) && (r_seq_len <= 3'(MAX_SEQ_BYTES))
                   && (r_lead == {1'b0, r_seq_len})
                   && (w_code32 >= tec_pkg::min_code(r_seq_len))
                   && !((w_code32 >= tec_pkg::SURR_LO) && (w_code32 <= tec_pkg::SURR_HI))
                   && (w_code32 != tec_pkg::NONCHAR0) && (w_code32 != tec_pkg::NONCHAR1);

    assign w_close_bad = (r_seq_len != 3'd0) && !w_seq_ok;

    always_comb begin
        case (r_bom_pos)
            2'd0: w_bits = r_bom_poss & {r_byte == tec_pkg::BYTE_EF,
                                         r_byte == tec_pkg::BYTE_FE,
                                         r_byte == tec_pkg::BYTE_FF};
            2'd1: w_bits = r_bom_poss & {r_byte == tec_pkg::BYTE_BB,
                                         r_byte == tec_pkg::BYTE_FF,
                                         r_byte == tec_pkg::BYTE_FE};
            2'd2: w_bits = r_bom_poss & {r_byte == tec_pkg::BYTE_BF, 2'b00};
            default: w_bits = 3'b000;
        endcase
    end

    always_comb begin
        w_text_fin = r_text;
        if (r_text != tec_pkg::TXT_HIGH && w_close_bad) begin
            w_text_fin = tec_pkg::TXT_HIGH;
        end
        if (!r_any) begin
            w_cls = tec_pkg::CLS_EMPTY;
        end else if (r_decided) begin
            w_cls = r_dec_class;
        end else if (r_sub) begin
            w_cls = tec_pkg::CLS_ASCII;
        end else begin
            case (w_text_fin)
                tec_pkg::TXT_ASCII: w_cls = tec_pkg::CLS_ASCII;
                tec_pkg::TXT_UTF8:  w_cls = tec_pkg::CLS_UTF8;
                default:            w_cls = tec_pkg::CLS_HIGH;
            endcase
        end
    end

    assign o_res.valid = r_v && r_end;
    assign o_res.cls   = w_cls;

    always_comb begin
        n_bom_pos   = r_bom_pos;
        n_bom_poss  = r_bom_poss;
        n_decided   = r_decided;
        n_dec_class = r_dec_class;
        n_text      = r_text;
        n_sub       = r_sub;
        n_seq_len   = r_seq_len;
        n_lead      = r_lead;
        n_code      = r_code;
        n_any       = r_any;
        w_text      = r_text;
        if (w_advance) begin
            if (r_end) begin
                n_bom_pos   = 2'd0;
                n_bom_poss  = 3'b111;
                n_decided   = 1'b0;
                n_dec_class = tec_pkg::CLS_BINARY;
                n_text      = tec_pkg::TXT_ASCII;
                n_sub       = 1'b0;
                n_seq_len   = 3'd0;
                n_lead      = 4'd0;
                n_code      = '0;
                n_any       = 1'b0;
            end else begin
                n_any = 1'b1;
                if (!r_decided) begin
                    if (r_sub) begin
                        n_decided   = 1'b1;
                        n_dec_class = tec_pkg::CLS_BINARY;
                    end else begin
                        n_bom_poss = w_bits;
                        n_bom_pos  = (r_bom_pos == 2'd3) ? 2'd3 : r_bom_pos + 2'd1;
                        if (r_bom_pos == 2'd1 && w_bits[0]) begin
                            n_decided   = 1'b1;
                            n_dec_class = tec_pkg::CLS_UTF16LE;
                        end else if (r_bom_pos == 2'd1 && w_bits[1]) begin
                            n_decided   = 1'b1;
                            n_dec_class = tec_pkg::CLS_UTF16BE;
                        end else if (r_bom_pos == 2'd2 && w_bits[2]) begin
                            n_decided   = 1'b1;
                            n_dec_class = tec_pkg::CLS_UTF8_BOM;
                        end else if (tec_pkg::is_forbidden(r_byte)) begin
                            if (r_byte == tec_pkg::BYTE_SUB) begin
                                n_sub = 1'b1;
                            end else begin
                                n_decided   = 1'b1;
                                n_dec_class = tec_pkg::CLS_BINARY;
                            end
                        end else begin
                            if (r_text == tec_pkg::TXT_ASCII && r_byte[7]) begin
                                w_text = tec_pkg::TXT_UTF8;
                            end
                            if (w_text != tec_pkg::TXT_HIGH) begin
                                if (!r_byte[7] || r_byte[6]) begin
                                    if (w_close_bad) begin
                                        w_text = tec_pkg::TXT_HIGH;
                                    end
                                    n_seq_len = 3'd0;
                                    if (r_byte[7]) begin
                                        n_lead    = w_lead;
                                        n_seq_len = 3'd1;
                                        n_code    = CODE_W'(r_byte & (8'hFF >> w_lead));
                                    end
                                end else if (r_seq_len == 3'd0) begin
                                    n_lead    = w_lead;
                                    n_seq_len = 3'd1;
                                    n_code    = CODE_W'(r_byte & (8'hFF >> w_lead));
                                end else if (r_seq_len >= 3'(MAX_SEQ_BYTES)) begin
                                    w_text = tec_pkg::TXT_HIGH;
                                end else begin
                                    n_seq_len = r_seq_len + 3'd1;
                                    n_code    = {r_code[CODE_W-7:0], r_byte[5:0]};
                                end
                            end
                            n_text = w_text;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_byte_value;
            r_end  <= i_end_marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= 1'b0;
            r_bom_pos   <= 2'd0;
            r_bom_poss  <= 3'b111;
            r_decided   <= 1'b0;
            r_dec_class <= tec_pkg::CLS_BINARY;
            r_text      <= tec_pkg::TXT_ASCII;
            r_sub       <= 1'b0;
            r_seq_len   <= 3'd0;
            r_lead      <= 4'd0;
            r_code      <= '0;
            r_any       <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_v <= i_valid;
            end
            r_bom_pos   <= n_bom_pos;
            r_bom_poss  <= n_bom_poss;
            r_decided   <= n_decided;
            r_dec_class <= n_dec_class;
            r_text      <= n_text;
            r_sub       <= n_sub;
            r_seq_len   <= n_seq_len;
            r_lead      <= n_lead;
            r_code      <= n_code;
            r_any       <= n_any;
        end
    end

endmodule

// ----- hw/rtl/tec_out_stage.sv -----
// Result register of the text encoding classifier, decoupling the core from the sink.
// Depends on tec_pkg.
module tec_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tec_pkg::t_result  i_res,
    output logic              o_out_free,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_encoding_class
);

    logic       r_o_valid;
    logic [2:0] r_cls;

    assign o_out_free       = !r_o_valid || !i_stall;
    assign o_valid          = r_o_valid;
    assign o_encoding_class = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_out_free) begin
            r_o_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_res.valid) begin
            r_cls <= i_res.cls;
        end
    end

endmodule

// ----- tb/tec_class_checker.sv -----
`timescale 1ns / 1ps
// Checker for the text encoding classifier. It watches both channels, predicts the class
// of each stream and compares every result word with the oldest prediction.
// Depends on tec_pkg for the class codes, the byte constants and the text state type.
module tec_class_checker #(
    parameter int MAX_SEQ = tec_pkg::MAX_SEQ_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_end_marker,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_encoding_class,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output logic [7:0] o_classes_seen
);
    import tec_pkg::*;

    // Bits 7 and 9 to 13 mark the control bytes that plain text may hold.
    localparam logic [31:0] PERMITTED_CONTROLS = 32'h0000_3E80;

    logic [1:0]  bom_idx;
    logic [2:0]  bom_alive;
    logic        locked;
    logic [2:0]  locked_cls;
    t_text       txt;
    logic        sub_held;
    int unsigned run_len;
    int unsigned run_lead;
    logic [31:0] run_code;
    logic        got_byte;

    logic [2:0]  expected_classes[$];
    int          fail_total = 0;
    int          checked_total = 0;
    logic [7:0]  seen_mask = '0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_classes_seen = '0;
    end

    task automatic clear_stream();
        bom_idx    = 2'd0;
        bom_alive  = 3'b111;
        locked     = 1'b0;
        locked_cls = CLS_BINARY;
        txt        = TXT_ASCII;
        sub_held   = 1'b0;
        run_len    = 0;
        run_lead   = 0;
        run_code   = '0;
        got_byte   = 1'b0;
    endtask

    function automatic int unsigned leading_ones(input logic [7:0] b);
        int unsigned n;
        n = 0;
        while (n < 8 && b[7 - n]) begin
            n++;
        end
        return n;
    endfunction

    function automatic logic [31:0] shortest_floor(input int unsigned n);
        case (n)
            2:       return 32'h0000_0080;
            3:       return 32'h0000_0800;
            4:       return 32'h0001_0000;
            5:       return 32'h0020_0000;
            6:       return 32'h0400_0000;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic run_is_valid();
        if (run_len < 2 || run_len > MAX_SEQ || run_lead != run_len) begin
            return 1'b0;
        end
        if (run_code < shortest_floor(run_len)) begin
            return 1'b0;
        end
        if (run_code >= SURR_LO && run_code <= SURR_HI) begin
            return 1'b0;
        end
        return !(run_code == NONCHAR0 || run_code == NONCHAR1);
    endfunction

    task automatic lock_class(input logic [2:0] cls);
        locked     = 1'b1;
        locked_cls = cls;
    endtask

    task automatic close_run();
        if (run_len != 0 && !run_is_valid()) begin
            txt = TXT_HIGH;
        end
        run_len = 0;
    endtask

    task automatic open_run(input logic [7:0] c);
        run_lead = leading_ones(c);
        run_len  = 1;
        run_code = {24'd0, c & (8'hFF >> run_lead)};
    endtask

    task automatic absorb_byte(input logic [7:0] c);
        logic [1:0] pos;
        logic [2:0] keep;
        pos      = bom_idx;
        got_byte = 1'b1;
        if (locked) begin
            return;
        end
        if (sub_held) begin
            lock_class(CLS_BINARY);
            return;
        end
        case (pos)
            2'd0:    keep = bom_alive & {c == BYTE_EF, c == BYTE_FE, c == BYTE_FF};
            2'd1:    keep = bom_alive & {c == BYTE_BB, c == BYTE_FF, c == BYTE_FE};
            2'd2:    keep = bom_alive & {c == BYTE_BF, 2'b00};
            default: keep = 3'b000;
        endcase
        bom_alive = keep;
        if (pos != 2'd3) begin
            bom_idx = pos + 2'd1;
        end
        if (pos == 2'd1 && keep[0]) begin
            lock_class(CLS_UTF16LE);
            return;
        end
        if (pos == 2'd1 && keep[1]) begin
            lock_class(CLS_UTF16BE);
            return;
        end
        if (pos == 2'd2 && keep[2]) begin
            lock_class(CLS_UTF8_BOM);
            return;
        end
        if (c < 8'h20 && !PERMITTED_CONTROLS[c[4:0]]) begin
            if (c == BYTE_SUB) begin
                sub_held = 1'b1;
            end else begin
                lock_class(CLS_BINARY);
            end
            return;
        end
        if (txt == TXT_ASCII && c[7]) begin
            txt = TXT_UTF8;
        end
        if (txt == TXT_HIGH) begin
            return;
        end
        if (!c[7] || c[6]) begin
            close_run();
            if (c[7]) begin
                open_run(c);
            end
        end else if (run_len == 0) begin
            open_run(c);
        end else if (run_len >= MAX_SEQ) begin
            txt = TXT_HIGH;
        end else begin
            run_len++;
            run_code = ((run_code << 6) | {26'd0, c[5:0]}) & 32'h7FFF_FFFF;
        end
    endtask

    function automatic logic [2:0] stream_class();
        if (!got_byte) begin
            return CLS_EMPTY;
        end
        if (locked) begin
            return locked_cls;
        end
        if (sub_held) begin
            return CLS_ASCII;
        end
        if (txt == TXT_HIGH || (run_len != 0 && !run_is_valid())) begin
            return CLS_HIGH;
        end
        return (txt == TXT_ASCII) ? CLS_ASCII : CLS_UTF8;
    endfunction

    always @(posedge i_clk) begin
        logic [2:0] want;
        if (!i_rst_n) begin
            clear_stream();
            expected_classes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen_mask[i_encoding_class] = 1'b1;
                if (expected_classes.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: unexpected result word, class %0d",
                                 $realtime, i_encoding_class);
                    end
                end else begin
                    want = expected_classes.pop_front();
                    checked_total++;
                    if (i_encoding_class !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: result %0d class mismatch: expected %0d, got %0d",
                                     $realtime, checked_total, want, i_encoding_class);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_end_marker) begin
                    expected_classes.push_back(stream_class());
                    clear_stream();
                end else begin
                    absorb_byte(i_byte_value);
                end
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= expected_classes.size();
        o_checked      <= checked_total;
        o_classes_seen <= seen_mask;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the text encoding classifier testbench: builds byte streams, drives them with
// varying idle and stall mixes and gives the verdict. Depends on tec_pkg, the block
// and tec_class_checker, which predicts and compares the results.
module testbench;
    import tec_pkg::*;

    localparam int WORD_TARGET = 1750;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [7:0] SOFT_CONTROLS [6] = '{8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    typedef struct {
        logic [7:0] data;
        logic       closes;
    } t_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_byte_value;
    logic       i_end_marker;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_encoding_class;

    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] classes_seen;

    t_word      words[$];
    int         stream_total = 0;
    int         byte_total = 0;
    int         recv_stall_pct = 65;
    logic       hold_req = 1'b0;
    int         cycle_count = 0;

    text_encoding_classifier_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_value     (i_byte_value),
        .i_end_marker     (i_end_marker),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_encoding_class (o_encoding_class)
    );

    tec_class_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_byte_value     (i_byte_value),
        .i_end_marker     (i_end_marker),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_encoding_class (o_encoding_class),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_classes_seen   (classes_seen)
    );

    task automatic push_byte(input logic [7:0] b);
        t_word w;
        w.data   = b;
        w.closes = 1'b0;
        words.push_back(w);
        byte_total++;
    endtask

    task automatic close_stream();
        t_word w;
        w.data   = 8'($urandom);
        w.closes = 1'b1;
        words.push_back(w);
        stream_total++;
    endtask

    function automatic logic [31:0] code_ceiling(input int n);
        case (n)
            1:       return 32'h0000_007F;
            2:       return 32'h0000_07FF;
            3:       return 32'h0000_FFFF;
            4:       return 32'h001F_FFFF;
            5:       return 32'h03FF_FFFF;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] shortest_code(input int n);
        logic [31:0] cp;
        cp = $urandom_range(code_ceiling(n), code_ceiling(n - 1) + 1);
        return cp;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 2;
        if (r < 70) return 3;
        if (r < 85) return 4;
        if (r < 93) return 5;
        return 6;
    endfunction

    // Emits the lead byte of an n-byte form and the first conts continuation bytes.
    task automatic push_code(input logic [31:0] cp, input int n, input int conts);
        push_byte(8'(8'hFF << (8 - n)) | 8'(cp >> (6 * (n - 1))));
        for (int k = n - 2; k >= n - 1 - conts; k--) begin
            push_byte(8'h80 | (8'(cp >> (6 * k)) & 8'h3F));
        end
    endtask

    task automatic push_ascii();
        int r;
        r = $urandom_range(19);
        if (r == 0) begin
            push_byte(SOFT_CONTROLS[$urandom_range(5)]);
        end else if (r == 1) begin
            push_byte(8'h7F);
        end else begin
            push_byte(8'($urandom_range(8'h7E, 8'h20)));
        end
    endtask

    task automatic push_char();
        int n;
        logic [31:0] cp;
        if ($urandom_range(2) == 0) begin
            push_ascii();
        end else begin
            n = pick_length();
            do begin
                cp = shortest_code(n);
            end while ((cp >= SURR_LO && cp <= SURR_HI) || cp == NONCHAR0 || cp == NONCHAR1);
            push_code(cp, n, n - 1);
        end
    endtask

    task automatic push_forbidden();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(31));
        end while (c inside {8'h07, [8'h09:8'h0D]});
        push_byte(c);
    endtask

    task automatic push_defect();
        int n;
        n = pick_length();
        case ($urandom_range(7))
            0: push_code($urandom_range(code_ceiling(n - 1), 0), n, n - 1);
            1: push_code($urandom_range(SURR_HI, SURR_LO), 3, 2);
            2: push_code(NONCHAR0 + $urandom_range(1), 3, 2);
            3: push_code(shortest_code(n), n, $urandom_range(n - 2));
            4: push_byte(8'($urandom_range(8'hBF, 8'h80)));
            5: begin
                push_code(shortest_code(6), 6, 5);
                repeat ($urandom_range(2, 1)) push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            6: begin
                push_byte(8'hFE | 8'($urandom_range(1)));
                repeat ($urandom_range(7)) push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            default: begin
                n = $urandom_range(4, 2);
                push_code(shortest_code(n), n, n - 1);
                push_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
        endcase
    endtask

    task automatic push_body(input int units, input int bad_pct);
        repeat (units) begin
            if ($urandom_range(99) < bad_pct) begin
                push_defect();
            end else begin
                push_char();
            end
        end
    endtask

    task automatic push_bom_prefix();
        case ($urandom_range(9))
            0: begin push_byte(BYTE_FF); push_byte(BYTE_FE); end
            1: begin push_byte(BYTE_FE); push_byte(BYTE_FF); end
            2: begin push_byte(BYTE_EF); push_byte(BYTE_BB); push_byte(BYTE_BF); end
            3: begin push_byte(BYTE_EF); push_byte(BYTE_BB); push_byte(8'hBE); end
            4: begin push_byte(BYTE_EF); push_byte(BYTE_BB); end
            5: begin push_byte(BYTE_FF); push_byte(BYTE_FF); end
            6: begin push_byte(BYTE_FE); push_byte(BYTE_FE); end
            7: push_byte(BYTE_FF);
            8: push_byte(BYTE_FE);
            default: begin push_byte(BYTE_EF); push_byte(BYTE_BF); end
        endcase
    endtask

    task automatic build_directed();
        close_stream();
        push_byte(BYTE_FF); push_byte(BYTE_FE); close_stream();
        push_byte(BYTE_FE); push_byte(BYTE_FF); close_stream();
        push_byte(BYTE_EF); push_byte(BYTE_BB); push_byte(BYTE_BF); close_stream();
        push_byte(8'h41); push_byte(BYTE_SUB); close_stream();
        push_byte(BYTE_SUB); push_byte(8'h41); close_stream();
        push_byte(8'hC3); push_byte(8'hA9); close_stream();
        push_byte(8'h80); close_stream();
        push_byte(8'h00); close_stream();
    endtask

    task automatic build_random_stream();
        int kind;
        kind = $urandom_range(19);
        if (kind < 2) begin
            repeat ($urandom_range(20, 1)) push_ascii();
        end else if (kind < 8 || kind == 19) begin
            push_body($urandom_range(12, 1), 0);
        end else if (kind < 11) begin
            push_body($urandom_range(12, 1), 30);
        end else if (kind < 13) begin
            push_bom_prefix();
            push_body($urandom_range(8), $urandom_range(1) * 30);
        end else if (kind == 13) begin
            repeat ($urandom_range(16, 1)) begin
                push_byte(8'($urandom_range(1) ? $urandom_range(8'hFF, 8'h80)
                                               : $urandom_range(8'h7E, 8'h20)));
            end
        end else if (kind < 16) begin
            case ($urandom_range(3))
                0: begin push_body($urandom_range(6), 10); push_forbidden();
                         push_body($urandom_range(6), 10); end
                1: begin push_body($urandom_range(8), 10); push_byte(BYTE_SUB); end
                2: begin push_body($urandom_range(6), 10); push_byte(BYTE_SUB);
                         push_body($urandom_range(4), 10); end
                default: begin repeat ($urandom_range(3, 1)) push_byte(BYTE_SUB); end
            endcase
        end else if (kind == 16) begin
            repeat ($urandom_range(20, 1)) push_byte(8'($urandom));
        end else if (kind == 17) begin
            if ($urandom_range(1)) push_byte(8'($urandom));
        end else begin
            push_body($urandom_range(6), 0);
            push_defect();
        end
        close_stream();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** text_encoding_classifier_unit: FAILED **");
        $finish;
    end

    initial begin : receiver
        logic hold_served;
        hold_served = 1'b0;
        forever begin
            if (hold_req && !hold_served) begin
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                hold_served = 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int n_total;
        int gap_pct;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_byte_value <= '0;
        i_end_marker <= 1'b0;
        build_directed();
        while (words.size() < WORD_TARGET) begin
            build_random_stream();
        end
        n_total = words.size();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < n_total; i++) begin
            if (i < n_total / 3) begin
                gap_pct = 11;
                recv_stall_pct <= 65;
            end else if (i < 2 * n_total / 3) begin
                gap_pct = 65;
                recv_stall_pct <= 11;
            end else begin
                gap_pct = 0;
                recv_stall_pct <= 0;
            end
            if (i == 2 * n_total / 3 + 40) begin
                hold_req <= 1'b1;
            end
            while ($urandom_range(99) < gap_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid      <= 1'b1;
            i_byte_value <= words[i].data;
            i_end_marker <= words[i].closes;
            @(posedge i_clk);
            while (o_stall) begin
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        $display("Drove %0d streams holding %0d bytes under three idle mixes and a %0d-cycle",
                 stream_total, byte_total, HOLD_CYCLES);
        $display("output hold; compared %0d classes, class codes seen (bit per code): %b",
                 checked, classes_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("** text_encoding_classifier_unit: PASSED **");
        end else begin
            $display("** text_encoding_classifier_unit: FAILED **");
        end
        $finish;
    end

endmodule
